>>> design/glyph_text_renderer_unit_defines.svh
// ----------------------------------------------------------------------------
// Glyph text renderer assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef GLYPH_TEXT_RENDERER_UNIT_DEFINES_SVH
`define GLYPH_TEXT_RENDERER_UNIT_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define GRT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("glyph text renderer check failed");

// Next-cycle implication, switched off while reset is held.
`define GRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("glyph text renderer check failed");

// Next-cycle implication that also holds across reset.
`define GRT_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("glyph text renderer check failed");

`endif

>>> design/grt_pkg.sv
// ----------------------------------------------------------------------------
// Glyph text renderer package
// Transaction types, operation codes and the two bitmap fonts.
// ----------------------------------------------------------------------------
package grt_pkg;

    localparam int COL_W = 7;
    localparam int ROW_W = 3;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] char_code;
        logic [3:0] cell_column;
        logic [2:0] text_row;
        logic [3:0] digit;
        logic [2:0] digit_shift;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       last;
    } t_out_item;

    typedef logic [2:0] t_kind;

    localparam t_kind K_NONE = 3'd0;
    localparam t_kind K_DATA = 3'd1;
    localparam t_kind K_CR   = 3'd2;
    localparam t_kind K_LF   = 3'd3;
    localparam t_kind K_SET  = 3'd4;

    localparam logic [1:0] FUNC_CHAR  = 2'd0;
    localparam logic [1:0] FUNC_SET   = 2'd1;
    localparam logic [1:0] FUNC_DIGIT = 2'd2;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_FIRST = 8'd32;
    localparam logic [7:0] CH_LAST  = 8'd127;

    localparam logic [3:0] DIGIT_LAST = 4'd10;

    localparam logic [7:0] CMD_X_ADDR = 8'h80;
    localparam logic [7:0] CMD_Y_ADDR = 8'h40;

    localparam logic [2:0] GLYPH_LAST_IDX = 3'd5;
    localparam logic [2:0] DIGIT_LAST_IDX = 3'd3;
    localparam logic [2:0] CMD_LAST_IDX   = 3'd1;

    // One operation as queued between the decoder and the byte sequencer.
    typedef struct packed {
        t_kind              kind;
        logic [2:0]         count_m1;
        logic [5:0][7:0]    bytes;
        logic [ROW_W-1:0]   set_row;
        logic [COL_W-1:0]   set_col;
    } t_desc;

    // Column 0 sits in the top byte of each entry.
    localparam logic [39:0] GLYPH_FONT [96] = '{
        40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_07_00_07_00, 40'h14_7F_14_7F_14,
        40'h24_2A_7F_2A_12, 40'h23_13_08_64_62, 40'h36_49_55_22_50, 40'h00_05_03_00_00,
        40'h00_1C_22_41_00, 40'h00_41_22_1C_00, 40'h14_08_3E_08_14, 40'h08_08_3E_08_08,
        40'h00_50_30_00_00, 40'h08_08_08_08_08, 40'h00_60_60_00_00, 40'h20_10_08_04_02,
        40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4B_31,
        40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h03_01_71_09_07,
        40'h36_49_49_49_36, 40'h06_49_49_29_16, 40'h00_36_36_00_00, 40'h00_56_36_00_00,
        40'h08_14_22_41_00, 40'h14_14_14_14_14, 40'h00_41_22_14_08, 40'h02_01_51_09_06,
        40'h32_49_79_41_3E, 40'h7E_11_11_11_7E, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22,
        40'h7F_41_41_22_1C, 40'h7F_49_49_49_41, 40'h7F_09_09_01_01, 40'h3E_41_49_49_3A,
        40'h7F_08_08_08_7F, 40'h00_41_7F_41_00, 40'h20_41_41_3F_01, 40'h7F_08_14_22_41,
        40'h7F_40_40_40_40, 40'h7F_02_0C_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E,
        40'h7F_09_09_09_06, 40'h3E_41_51_21_5E, 40'h7F_09_19_29_46, 40'h26_49_49_49_32,
        40'h01_01_7F_01_01, 40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h3F_40_38_40_3F,
        40'h63_14_08_14_63, 40'h07_08_70_08_07, 40'h61_51_49_45_43, 40'h00_7F_41_41_00,
        40'h02_04_08_10_20, 40'h00_41_41_7F_00, 40'h04_02_01_02_04, 40'h40_40_40_40_40,
        40'h00_01_02_04_00, 40'h20_54_54_54_78, 40'h7F_48_44_44_38, 40'h38_44_44_44_20,
        40'h38_44_44_48_3F, 40'h38_54_54_54_18, 40'h08_7E_09_01_02, 40'h0C_52_52_52_3E,
        40'h7F_08_04_04_78, 40'h00_44_7D_40_00, 40'h20_40_45_3C_00, 40'h7F_10_28_44_00,
        40'h00_41_7F_40_00, 40'h7C_04_18_04_78, 40'h7C_08_04_04_78, 40'h38_44_44_44_38,
        40'h7C_14_14_14_08, 40'h08_14_14_18_7C, 40'h7C_08_04_04_08, 40'h48_54_54_54_20,
        40'h04_3F_44_40_20, 40'h3C_40_40_20_7C, 40'h1C_20_40_20_1C, 40'h3C_40_30_40_3C,
        40'h44_28_10_28_44, 40'h0C_50_50_50_3C, 40'h44_64_54_4C_44, 40'h00_08_36_41_00,
        40'h00_00_7F_00_00, 40'h00_41_36_08_00, 40'h10_08_08_10_08, 40'h08_1C_2A_08_08
    };

    localparam logic [31:0] DIGIT_FONT [11] = '{
        32'h0e_15_0e_00, 32'h12_1f_10_00, 32'h12_19_16_00, 32'h11_15_0b_00,
        32'h07_04_1f_00, 32'h17_15_09_00, 32'h0e_15_09_00, 32'h19_05_03_00,
        32'h1a_15_0b_00, 32'h12_15_0e_00, 32'h00_10_00_00
    };

endpackage

>>> design/grt_front.sv
// ----------------------------------------------------------------------------
// Glyph text renderer decoder
// Classifies each incoming operation and prepares its queue entry.
// ----------------------------------------------------------------------------
module grt_front #(
    parameter int DISPLAY_WIDTH = 84,
    parameter int DISPLAY_LINES = 6
) (
    input  logic              i_in_valid,
    input  grt_pkg::t_in_item i_in,
    input  logic              i_queue_ready,
    output logic              o_in_ready,
    output logic              o_push,
    output grt_pkg::t_desc    o_desc
);
    import grt_pkg::*;

    logic [COL_W-1:0] col_tab [16];
    logic [ROW_W-1:0] row_tab [8];

    // Set-cursor targets are taken modulo the display size through small tables.
    for (genvar g = 0; g < 16; g++) begin : g_col_tab
        assign col_tab[g] = COL_W'((6 * g) % DISPLAY_WIDTH);
    end
    for (genvar g = 0; g < 8; g++) begin : g_row_tab
        assign row_tab[g] = ROW_W'(g % DISPLAY_LINES);
    end

    logic        glyph_ok;
    logic [6:0]  glyph_idx;
    logic [39:0] glyph_bits;
    logic [3:0]  digit_idx;
    logic [31:0] digit_bits;
    t_kind       kind;

    function automatic logic [7:0] glyph_shift(input logic [7:0] col, input logic [2:0] sh);
        glyph_shift = col << sh;
    endfunction

    always_comb begin
        glyph_ok   = (i_in.char_code >= CH_FIRST) && (i_in.char_code <= CH_LAST);
        glyph_idx  = glyph_ok ? 7'(i_in.char_code - CH_FIRST) : 7'd0;
        glyph_bits = GLYPH_FONT[glyph_idx];
        digit_idx  = (i_in.digit <= DIGIT_LAST) ? i_in.digit : 4'd0;
        digit_bits = (i_in.digit <= DIGIT_LAST) ? DIGIT_FONT[digit_idx] : 32'd0;

        case (i_in.func)
            FUNC_CHAR: begin
                if (i_in.char_code == CH_CR) begin
                    kind = K_CR;
                end else if (i_in.char_code == CH_LF) begin
                    kind = K_LF;
                end else if (glyph_ok) begin
                    kind = K_DATA;
                end else begin
                    kind = K_NONE;
                end
            end
            FUNC_SET:   kind = K_SET;
            FUNC_DIGIT: kind = K_DATA;
            default:    kind = K_NONE;
        endcase

        o_desc.kind    = kind;
        o_desc.set_row = row_tab[i_in.text_row];
        o_desc.set_col = col_tab[i_in.cell_column];
        o_desc.bytes   = '0;
        if (i_in.func == FUNC_DIGIT) begin
            o_desc.count_m1 = DIGIT_LAST_IDX;
            for (int i = 0; i < 4; i++) begin
                o_desc.bytes[i] = glyph_shift(digit_bits[31 - 8*i -: 8], i_in.digit_shift);
            end
        end else if (kind == K_DATA) begin
            o_desc.count_m1 = GLYPH_LAST_IDX;
            for (int i = 0; i < 5; i++) begin
                o_desc.bytes[i] = {glyph_bits[38 - 8*i -: 7], 1'b0};
            end
        end else begin
            o_desc.count_m1 = CMD_LAST_IDX;
        end
    end

    // Operations that produce nothing are accepted and dropped here.
    assign o_in_ready = i_queue_ready;
    assign o_push     = i_in_valid && i_queue_ready && (kind != K_NONE);

endmodule

>>> design/grt_queue.sv
// ----------------------------------------------------------------------------
// Glyph text renderer operation queue
// Two-entry queue between the decoder and the byte sequencer.
// ----------------------------------------------------------------------------
module grt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  grt_pkg::t_desc i_push_desc,
    output logic           o_push_ready,
    output logic           o_pop_valid,
    output grt_pkg::t_desc o_pop_desc,
    input  logic           i_pop
);
    import grt_pkg::*;

    t_desc      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;
    logic       do_push;
    logic       do_pop;

    always_comb begin
        o_push_ready = (r_count != 2'd2);
        o_pop_valid  = (r_count != 2'd0);
        o_pop_desc   = r_mem[r_rd_ptr];
        do_push      = i_push && o_push_ready;
        do_pop       = i_pop && o_pop_valid;
        n_wr_ptr     = do_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr     = do_pop ? !r_rd_ptr : r_rd_ptr;
        n_count      = r_count + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_desc;
        end
    end

endmodule

>>> design/grt_back.sv
// ----------------------------------------------------------------------------
// Glyph text renderer byte sequencer
// Emits one byte per cycle from the queued operation while the output is ready, and tracks the cursor.
// ----------------------------------------------------------------------------
module grt_back #(
    parameter int DISPLAY_WIDTH = 84,
    parameter int DISPLAY_LINES = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_head_valid,
    input  grt_pkg::t_desc     i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output grt_pkg::t_out_item o_out
);
    import grt_pkg::*;

    logic [2:0]       r_idx;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic             r_out_valid;
    t_out_item        r_out;

    logic [2:0]       n_idx;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;

    logic             emit;
    logic             is_last;
    logic             is_cmd;
    logic [ROW_W-1:0] row_inc;
    logic [ROW_W-1:0] tgt_row;
    logic [COL_W-1:0] tgt_col;
    t_out_item        item;

    always_comb begin
        emit    = i_head_valid && (!r_out_valid || i_out_ready);
        is_last = (r_idx == i_head.count_m1);
        is_cmd  = (i_head.kind != K_DATA);
        row_inc = (r_row == ROW_W'(DISPLAY_LINES - 1)) ? '0 : r_row + ROW_W'(1);

        case (i_head.kind)
            K_CR: begin
                tgt_row = r_row;
                tgt_col = '0;
            end
            K_LF: begin
                tgt_row = row_inc;
                tgt_col = r_col;
            end
            K_SET: begin
                tgt_row = i_head.set_row;
                tgt_col = i_head.set_col;
            end
            default: begin
                tgt_row = r_row;
                tgt_col = r_col;
            end
        endcase

        item.is_data = !is_cmd;
        item.last    = is_last;
        if (!is_cmd) begin
            item.out_byte = i_head.bytes[r_idx];
        end else if (r_idx[0]) begin
            item.out_byte = CMD_Y_ADDR | {5'd0, tgt_row};
        end else begin
            item.out_byte = CMD_X_ADDR | {1'b0, tgt_col};
        end

        n_idx = r_idx;
        n_col = r_col;
        n_row = r_row;
        if (emit) begin
            n_idx = is_last ? 3'd0 : r_idx + 3'd1;
            if (!is_cmd) begin
                // Each data byte steps the column; a full line moves on a row.
                if (r_col == COL_W'(DISPLAY_WIDTH - 1)) begin
                    n_col = '0;
                    n_row = row_inc;
                end else begin
                    n_col = r_col + COL_W'(1);
                end
            end else if (is_last) begin
                n_col = tgt_col;
                n_row = tgt_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 3'd0;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            r_col <= n_col;
            r_row <= n_row;
            if (!r_out_valid || i_out_ready) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= item;
        end
    end

    assign o_pop       = emit && is_last;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> design/glyph_text_renderer_unit.sv
// The first byte of an operation passes through the queue and the registered output stage.
// Throughput: one output byte per cycle while the output is ready, from a single registered
// output stage; a glyph is 6 bytes, a small digit 4 and an address command pair 2.
// A two-entry queue lets the next operation be accepted while bytes are still leaving.
// Reset (synchronous, active low) empties the queue, drops the output and homes the cursor.
// ----------------------------------------------------------------------------
// Glyph text renderer
// Turns text operations into data and command bytes for a graphic display.
// ----------------------------------------------------------------------------
module glyph_text_renderer_unit #(
    parameter int DISPLAY_WIDTH = 84,
    parameter int DISPLAY_LINES = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  grt_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output grt_pkg::t_out_item o_out
);
    import grt_pkg::*;

    logic  queue_ready;
    logic  push;
    t_desc push_desc;
    logic  head_valid;
    t_desc head;
    logic  pop;

    grt_front #(
        .DISPLAY_WIDTH (DISPLAY_WIDTH),
        .DISPLAY_LINES (DISPLAY_LINES)
    ) u_front (
        .i_in_valid    (i_in_valid),
        .i_in          (i_in),
        .i_queue_ready (queue_ready),
        .o_in_ready    (o_in_ready),
        .o_push        (push),
        .o_desc        (push_desc)
    );

    grt_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_desc  (push_desc),
        .o_push_ready (queue_ready),
        .o_pop_valid  (head_valid),
        .o_pop_desc   (head),
        .i_pop        (pop)
    );

    grt_back #(
        .DISPLAY_WIDTH (DISPLAY_WIDTH),
        .DISPLAY_LINES (DISPLAY_LINES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out        (o_out)
    );

endmodule

>>> design/grt_checker.sv
// ----------------------------------------------------------------------------
// Glyph text renderer port checker
// Watches the output channel of the renderer and is bound to its top level.
// ----------------------------------------------------------------------------
`include "glyph_text_renderer_unit_defines.svh"

module grt_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input grt_pkg::t_out_item i_out
);
    import grt_pkg::*;

    // A stalled transaction keeps its byte and flags.
    `GRT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out))

    // Nothing is offered in the cycle after reset.
    `GRT_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n, !i_out_valid)

    // An address pair opens with the X command.
    `GRT_ASSERT_NOW(a_cmd_x, i_clk, i_rst_n, i_out_valid && !i_out.is_data && !i_out.last, i_out.out_byte[7])

    // An address pair closes with the Y command, right after its X command.
    `GRT_ASSERT_NOW(a_cmd_y, i_clk, i_rst_n, i_out_valid && !i_out.is_data && i_out.last, i_out.out_byte[7:3] == 5'b01000)

endmodule

bind glyph_text_renderer_unit grt_checker u_grt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out       (o_out)
);
